### design/oepr_pkg.sv
// ----------------------------------------------------------------------------
// oepr_pkg
// Shared types and constants for the opposite edge pair remover.
// ----------------------------------------------------------------------------
package oepr_pkg;

   localparam int MAX_EDGES_DEF   = 64;
   localparam int VERTEX_BITS_DEF = 16;
   localparam int FIELD_W         = 16;
   localparam int POS_W           = 6;

   typedef struct packed {
      logic [FIELD_W-1:0] start_vertex;
      logic [FIELD_W-1:0] end_vertex;
      logic               last_edge;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] out_start;
      logic [FIELD_W-1:0] out_end;
      logic [POS_W-1:0]   original_position;
      logic               last_result;
      logic               list_empty;
      logic               overflowed;
   } rsp_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic shift;
      logic clear;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SETTLE,
      ST_DRAIN
   } state_type;

endpackage

### design/opposite_edge_pair_remover.sv
// Sequence: a load phase takes one edge per cycle, then a settle phase waits
// while the last edge ripples through the cell chain, then a drain phase shifts
// the chain out and emits survivors in order, holding while rsp_stall is set.
// Requests stall outside the load phase, so a new list waits for the last to drain.
// Reset: synchronous; clears the sequencer and cell valid bits, edge data is not reset.
// ----------------------------------------------------------------------------
// opposite_edge_pair_remover
// Cancels pairs of opposite directed edges in a systolic cell chain.
// ----------------------------------------------------------------------------
module opposite_edge_pair_remover
   import oepr_pkg::*;
#(
   parameter int MAX_EDGES   = MAX_EDGES_DEF,
   parameter int VERTEX_BITS = VERTEX_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int VTX_W = (VERTEX_BITS < FIELD_W) ? VERTEX_BITS : FIELD_W;
   localparam int CNT_W = $clog2(MAX_EDGES + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] load_cnt_ff, load_cnt_in;
   logic             ovf_ff, ovf_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [VTX_W-1:0] pend_sv_ff, pend_sv_in;
   logic [VTX_W-1:0] pend_ev_ff, pend_ev_in;
   logic [POS_W-1:0] pend_pos_ff, pend_pos_in;
   logic             rsp_vld_ff, rsp_vld_in;
   rsp_type          rsp_ff, rsp_in;
   ctl_type          ctl;
   logic             accept;
   logic             full;
   logic             out_free;

   logic             tok_vld [0:MAX_EDGES];
   logic [VTX_W-1:0] tok_sv  [0:MAX_EDGES];
   logic [VTX_W-1:0] tok_ev  [0:MAX_EDGES];
   logic [POS_W-1:0] tok_pos [0:MAX_EDGES];
   logic             live    [0:MAX_EDGES];
   logic [VTX_W-1:0] sv      [0:MAX_EDGES];
   logic [VTX_W-1:0] ev      [0:MAX_EDGES];
   logic [POS_W-1:0] pos     [0:MAX_EDGES];

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign full      = (load_cnt_ff == CNT_W'(MAX_EDGES));
   assign out_free  = !rsp_vld_ff || !rsp_stall;

   // new edge enters the head of the chain; edges past capacity are dropped
   assign tok_vld[0] = accept && !full;
   assign tok_sv[0]  = req_data.start_vertex[VTX_W-1:0];
   assign tok_ev[0]  = req_data.end_vertex[VTX_W-1:0];
   assign tok_pos[0] = POS_W'(load_cnt_ff);

   assign live[MAX_EDGES] = 1'b0;
   assign sv[MAX_EDGES]   = '0;
   assign ev[MAX_EDGES]   = '0;
   assign pos[MAX_EDGES]  = '0;

   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      oepr_cell #(
         .VTX_W (VTX_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .tok_vld_i  (tok_vld[i]),
         .tok_sv_i   (tok_sv[i]),
         .tok_ev_i   (tok_ev[i]),
         .tok_pos_i  (tok_pos[i]),
         .tok_vld_o  (tok_vld[i+1]),
         .tok_sv_o   (tok_sv[i+1]),
         .tok_ev_o   (tok_ev[i+1]),
         .tok_pos_o  (tok_pos[i+1]),
         .nxt_live_i (live[i+1]),
         .nxt_sv_i   (sv[i+1]),
         .nxt_ev_i   (ev[i+1]),
         .nxt_pos_i  (pos[i+1]),
         .live_o     (live[i]),
         .sv_o       (sv[i]),
         .ev_o       (ev[i]),
         .pos_o      (pos[i])
      );
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      load_cnt_in = load_cnt_ff;
      ovf_in      = ovf_ff;
      pend_vld_in = pend_vld_ff;
      pend_sv_in  = pend_sv_ff;
      pend_ev_in  = pend_ev_ff;
      pend_pos_in = pend_pos_ff;
      rsp_vld_in  = rsp_vld_ff && rsp_stall;
      rsp_in      = rsp_ff;
      ctl.shift   = 1'b0;
      ctl.clear   = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
               if (req_data.last_edge) begin
                  state_in = ST_SETTLE;
                  cnt_in   = '0;
               end
            end
         end
         ST_SETTLE: begin
            // wait until the last edge has passed the whole chain
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAX_EDGES - 1)) begin
               state_in = ST_DRAIN;
               cnt_in   = '0;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               if (cnt_ff != CNT_W'(MAX_EDGES)) begin
                  ctl.shift = 1'b1;
                  cnt_in    = cnt_ff + 1'b1;
                  // one survivor held back so the final one can be flagged
                  if (live[0]) begin
                     if (pend_vld_ff) begin
                        rsp_vld_in                 = 1'b1;
                        rsp_in.out_start           = FIELD_W'(pend_sv_ff);
                        rsp_in.out_end             = FIELD_W'(pend_ev_ff);
                        rsp_in.original_position   = pend_pos_ff;
                        rsp_in.last_result         = 1'b0;
                        rsp_in.list_empty          = 1'b0;
                        rsp_in.overflowed          = ovf_ff;
                     end
                     pend_vld_in = 1'b1;
                     pend_sv_in  = sv[0];
                     pend_ev_in  = ev[0];
                     pend_pos_in = pos[0];
                  end
               end else begin
                  rsp_vld_in               = 1'b1;
                  rsp_in.out_start         = pend_vld_ff ? FIELD_W'(pend_sv_ff) : '0;
                  rsp_in.out_end           = pend_vld_ff ? FIELD_W'(pend_ev_ff) : '0;
                  rsp_in.original_position = pend_vld_ff ? pend_pos_ff : '0;
                  rsp_in.last_result       = 1'b1;
                  rsp_in.list_empty        = !pend_vld_ff;
                  rsp_in.overflowed        = ovf_ff;
                  ctl.clear                = 1'b1;
                  state_in                 = ST_LOAD;
                  cnt_in                   = '0;
                  load_cnt_in              = '0;
                  ovf_in                   = 1'b0;
                  pend_vld_in              = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         cnt_ff      <= '0;
         load_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         load_cnt_ff <= load_cnt_in;
         ovf_ff      <= ovf_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_sv_ff  <= pend_sv_in;
      pend_ev_ff  <= pend_ev_in;
      pend_pos_ff <= pend_pos_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/oepr_cell.sv
// ----------------------------------------------------------------------------
// oepr_cell
// One slot of the edge chain: holds a stored edge and a travelling item.
// ----------------------------------------------------------------------------
module oepr_cell
   import oepr_pkg::*;
#(
   parameter int VTX_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  ctl_type            ctl,
   // travelling edge from the previous cell
   input  logic               tok_vld_i,
   input  logic [VTX_W-1:0]   tok_sv_i,
   input  logic [VTX_W-1:0]   tok_ev_i,
   input  logic [POS_W-1:0]   tok_pos_i,
   output logic               tok_vld_o,
   output logic [VTX_W-1:0]   tok_sv_o,
   output logic [VTX_W-1:0]   tok_ev_o,
   output logic [POS_W-1:0]   tok_pos_o,
   // stored edge from the next cell, used while draining
   input  logic               nxt_live_i,
   input  logic [VTX_W-1:0]   nxt_sv_i,
   input  logic [VTX_W-1:0]   nxt_ev_i,
   input  logic [POS_W-1:0]   nxt_pos_i,
   output logic               live_o,
   output logic [VTX_W-1:0]   sv_o,
   output logic [VTX_W-1:0]   ev_o,
   output logic [POS_W-1:0]   pos_o
);

   logic             used_ff, used_in;
   logic             live_ff, live_in;
   logic [VTX_W-1:0] sv_ff, sv_in;
   logic [VTX_W-1:0] ev_ff, ev_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             tokv_ff, tokv_in;
   logic [VTX_W-1:0] toks_ff, toks_in;
   logic [VTX_W-1:0] toke_ff, toke_in;
   logic [POS_W-1:0] tokp_ff, tokp_in;
   logic             hit;
   logic             take;

   always_comb begin
      hit  = tok_vld_i && live_ff && (sv_ff == tok_ev_i) && (ev_ff == tok_sv_i);
      // settle only in a never-used slot so the chain keeps load order
      take = tok_vld_i && !used_ff;

      used_in = used_ff;
      live_in = live_ff;
      sv_in   = sv_ff;
      ev_in   = ev_ff;
      pos_in  = pos_ff;
      tokv_in = 1'b0;
      toks_in = tok_sv_i;
      toke_in = tok_ev_i;
      tokp_in = tok_pos_i;

      if (ctl.clear) begin
         used_in = 1'b0;
         live_in = 1'b0;
      end else if (ctl.shift) begin
         live_in = nxt_live_i;
         sv_in   = nxt_sv_i;
         ev_in   = nxt_ev_i;
         pos_in  = nxt_pos_i;
      end else begin
         if (hit) begin
            live_in = 1'b0;
         end
         if (take) begin
            used_in = 1'b1;
            live_in = 1'b1;
            sv_in   = tok_sv_i;
            ev_in   = tok_ev_i;
            pos_in  = tok_pos_i;
         end
         tokv_in = tok_vld_i && !hit && !take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
         live_ff <= 1'b0;
         tokv_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
         live_ff <= live_in;
         tokv_ff <= tokv_in;
      end
   end

   always_ff @(posedge clock) begin
      sv_ff   <= sv_in;
      ev_ff   <= ev_in;
      pos_ff  <= pos_in;
      toks_ff <= toks_in;
      toke_ff <= toke_in;
      tokp_ff <= tokp_in;
   end

   assign tok_vld_o = tokv_ff;
   assign tok_sv_o  = toks_ff;
   assign tok_ev_o  = toke_ff;
   assign tok_pos_o = tokp_ff;
   assign live_o    = live_ff;
   assign sv_o      = sv_ff;
   assign ev_o      = ev_ff;
   assign pos_o     = pos_ff;

endmodule

### tb/opposite_edge_pair_remover_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// opposite_edge_pair_remover_tb
// Feeds edge lists through the remover and checks every surviving edge, its
// load position and the list flags against an in-bench cancel predictor.
// A short directed table comes first, then full and overflowing lists, then
// random lists built so that nested opposite pairs appear often.
// ----------------------------------------------------------------------------
module opposite_edge_pair_remover_tb;
   import oepr_pkg::*;

   localparam int EDGE_CAP     = MAX_EDGES_DEF;
   localparam int TARGET_ITEMS = 430;
   localparam int QUIET_AFTER  = 380;
   localparam int STUCK_LIMIT  = 3000;
   localparam int DIR_ROWS     = 25;

   typedef struct packed {
      logic [FIELD_W-1:0] start_vertex;
      logic [FIELD_W-1:0] end_vertex;
      logic               last_edge;
      logic               typed;
      rsp_type            want;
   } dir_row_type;

   // start, end, last, typed, then the typed result where one is given
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      // lone self-loops at both extremes survive
      {16'h0000, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h0000, 6'd0, 1'b1, 1'b0, 1'b0},
      {16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 6'd0, 1'b1, 1'b0, 1'b0},
      // extreme pair cancels to an empty list
      {16'hFFFF, 16'h0000, 1'b0, 1'b0, 41'd0},
      {16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 16'h0000, 6'd0, 1'b1, 1'b1, 1'b0},
      // two equal self-loops cancel each other
      {16'h0007, 16'h0007, 1'b0, 1'b0, 41'd0},
      {16'h0007, 16'h0007, 1'b1, 1'b1, 16'h0000, 16'h0000, 6'd0, 1'b1, 1'b1, 1'b0},
      // triangle, nothing cancels
      {16'h0001, 16'h0002, 1'b0, 1'b0, 41'd0},
      {16'h0002, 16'h0003, 1'b0, 1'b0, 41'd0},
      {16'h0003, 16'h0001, 1'b1, 1'b0, 41'd0},
      // nested pairs, needs two passes
      {16'h0001, 16'h0002, 1'b0, 1'b0, 41'd0},
      {16'h0003, 16'h0004, 1'b0, 1'b0, 41'd0},
      {16'h0004, 16'h0003, 1'b0, 1'b0, 41'd0},
      {16'h0002, 16'h0001, 1'b0, 1'b0, 41'd0},
      {16'h0007, 16'h0008, 1'b1, 1'b1, 16'h0007, 16'h0008, 6'd4, 1'b1, 1'b0, 1'b0},
      // two candidate partners, the first one is taken
      {16'h0001, 16'h0002, 1'b0, 1'b0, 41'd0},
      {16'h0002, 16'h0001, 1'b0, 1'b0, 41'd0},
      {16'h0002, 16'h0001, 1'b1, 1'b1, 16'h0002, 16'h0001, 6'd2, 1'b1, 1'b0, 1'b0},
      // same-direction duplicates never cancel
      {16'h0009, 16'h000A, 1'b0, 1'b0, 41'd0},
      {16'h0009, 16'h000A, 1'b0, 1'b0, 41'd0},
      {16'h000A, 16'h000B, 1'b1, 1'b0, 41'd0},
      // earliest edge with a partner wins
      {16'h0003, 16'h0004, 1'b0, 1'b0, 41'd0},
      {16'h0001, 16'h0002, 1'b0, 1'b0, 41'd0},
      {16'h0004, 16'h0003, 1'b0, 1'b0, 41'd0},
      {16'h0002, 16'h0001, 1'b0, 1'b0, 41'd0},
      {16'h0001, 16'h0002, 1'b1, 1'b1, 16'h0001, 16'h0002, 6'd4, 1'b1, 1'b0, 1'b0}
   };

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // cancel predictor state
   logic [FIELD_W-1:0] held_start [EDGE_CAP];
   logic [FIELD_W-1:0] held_end [EDGE_CAP];
   logic [POS_W-1:0]   held_pos [EDGE_CAP];
   int unsigned        edges_held;
   bit                 dropped_any;
   rsp_type            list_survivors [$];

   rsp_type survivors_due [$];
   int      mismatches;
   int      items_sent;
   int      stuck_cycles;
   bit      feed_gaps;
   bit      drain_gaps;

   opposite_edge_pair_remover i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stores one edge; on the last edge cancels pairs until stable and
   // leaves the survivors in list_survivors. Returns the result count.
   function automatic int absorb_edge(input req_type edge_in);
      int i, j, k, w, hit_i, hit_j;
      bit hit;
      rsp_type r;
      list_survivors.delete();
      if (edges_held < EDGE_CAP) begin
         held_start[edges_held] = edge_in.start_vertex;
         held_end[edges_held]   = edge_in.end_vertex;
         held_pos[edges_held]   = edges_held[POS_W-1:0];
         edges_held++;
      end else begin
         dropped_any = 1'b1;
      end
      if (!edge_in.last_edge) return 0;
      do begin
         hit = 1'b0;
         hit_i = 0;
         hit_j = 0;
         for (i = 0; i < edges_held && !hit; i++) begin
            for (j = i + 1; j < edges_held && !hit; j++) begin
               if (held_start[j] == held_end[i] && held_end[j] == held_start[i]) begin
                  hit = 1'b1;
                  hit_i = i;
                  hit_j = j;
               end
            end
         end
         if (hit) begin
            w = 0;
            for (k = 0; k < edges_held; k++) begin
               if (k != hit_i && k != hit_j) begin
                  held_start[w] = held_start[k];
                  held_end[w]   = held_end[k];
                  held_pos[w]   = held_pos[k];
                  w++;
               end
            end
            edges_held = w;
         end
      end while (hit);
      if (edges_held == 0) begin
         r = '0;
         r.last_result = 1'b1;
         r.list_empty  = 1'b1;
         r.overflowed  = dropped_any;
         list_survivors.push_back(r);
      end else begin
         for (k = 0; k < edges_held; k++) begin
            r.out_start         = held_start[k];
            r.out_end           = held_end[k];
            r.original_position = held_pos[k];
            r.last_result       = (k + 1 == edges_held);
            r.list_empty        = 1'b0;
            r.overflowed        = dropped_any;
            list_survivors.push_back(r);
         end
      end
      edges_held  = 0;
      dropped_any = 1'b0;
      return list_survivors.size();
   endfunction

   // Hands one edge to the block, then books what it should produce.
   task automatic feed_edge(input req_type edge_in, input bit typed, input rsp_type want);
      int gap;
      int n;
      if (feed_gaps && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= edge_in;
      do @(posedge clock); while (req_stall);
      n = absorb_edge(edge_in);
      if (n > 0) begin
         if (typed) survivors_due.push_back(want);
         else foreach (list_survivors[k]) survivors_due.push_back(list_survivors[k]);
      end
      items_sent++;
   endtask

   // Random list; reversed copies of earlier edges build nested pairs.
   task automatic feed_random_list(input int len);
      logic [FIELD_W-1:0] pool [8];
      logic [FIELD_W-1:0] sent_start [$];
      logic [FIELD_W-1:0] sent_end [$];
      req_type e;
      int flavor, pick;
      flavor = $urandom_range(0, 3);
      for (int k = 0; k < 8; k++) begin
         case (flavor)
            0: pool[k] = FIELD_W'(k);
            1: pool[k] = FIELD_W'($urandom);
            default: pool[k] = (k == 0) ? '0 : (k == 1) ? '1 : FIELD_W'($urandom);
         endcase
      end
      for (int k = 0; k < len; k++) begin
         if (k > 0 && $urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, sent_start.size() - 1);
            e.start_vertex = sent_end[pick];
            e.end_vertex   = sent_start[pick];
         end else if (flavor == 3) begin
            e.start_vertex = FIELD_W'($urandom);
            e.end_vertex   = FIELD_W'($urandom);
         end else begin
            e.start_vertex = pool[$urandom_range(0, 7)];
            e.end_vertex   = pool[$urandom_range(0, 7)];
         end
         e.last_edge = (k == len - 1);
         sent_start.push_back(e.start_vertex);
         sent_end.push_back(e.end_vertex);
         feed_edge(e, 1'b0, '0);
      end
   endtask

   // Result side: random stall bursts while drain_gaps is set.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (drain_gaps && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (survivors_due.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            mismatches++;
         end else begin
            want = survivors_due.pop_front();
            if (rsp_data.out_start !== want.out_start) begin
               $error("out_start: expected %h, got %h", want.out_start, rsp_data.out_start);
               mismatches++;
            end
            if (rsp_data.out_end !== want.out_end) begin
               $error("out_end: expected %h, got %h", want.out_end, rsp_data.out_end);
               mismatches++;
            end
            if (rsp_data.original_position !== want.original_position) begin
               $error("original_position: expected %0d, got %0d",
                      want.original_position, rsp_data.original_position);
               mismatches++;
            end
            if (rsp_data.last_result !== want.last_result) begin
               $error("last_result: expected %b, got %b", want.last_result,
                      rsp_data.last_result);
               mismatches++;
            end
            if (rsp_data.list_empty !== want.list_empty) begin
               $error("list_empty: expected %b, got %b", want.list_empty, rsp_data.list_empty);
               mismatches++;
            end
            if (rsp_data.overflowed !== want.overflowed) begin
               $error("overflowed: expected %b, got %b", want.overflowed, rsp_data.overflowed);
               mismatches++;
            end
         end
      end
   end

   // watchdog: cycles with no item moving on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
               $display("FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      req_type e;
      int len, pick;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      edges_held   = 0;
      dropped_any  = 1'b0;
      mismatches   = 0;
      items_sent   = 0;
      stuck_cycles = 0;
      feed_gaps    = 1'b1;
      drain_gaps   = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r]) begin
         e.start_vertex = DIRECTED[r].start_vertex;
         e.end_vertex   = DIRECTED[r].end_vertex;
         e.last_edge    = DIRECTED[r].last_edge;
         feed_edge(e, DIRECTED[r].typed, DIRECTED[r].want);
      end

      // full store of mutually cancelling pairs, last edge dropped
      for (int k = 0; k <= EDGE_CAP; k++) begin
         if (k < EDGE_CAP / 2) begin
            e.start_vertex = FIELD_W'(k);
            e.end_vertex   = FIELD_W'(k + 16'h0100);
         end else if (k < EDGE_CAP) begin
            e.start_vertex = FIELD_W'(EDGE_CAP - 1 - k + 16'h0100);
            e.end_vertex   = FIELD_W'(EDGE_CAP - 1 - k);
         end else begin
            e.start_vertex = 16'h0001;
            e.end_vertex   = 16'h0002;
         end
         e.last_edge = (k == EDGE_CAP);
         feed_edge(e, 1'b0, '0);
      end
      // exactly full, random content
      feed_random_list(EDGE_CAP);

      while (items_sent < TARGET_ITEMS) begin
         if (items_sent >= QUIET_AFTER) begin
            feed_gaps  = 1'b0;
            drain_gaps = 1'b0;
         end else begin
            pick       = $urandom_range(0, 3);
            feed_gaps  = pick[0];
            drain_gaps = pick[1];
         end
         pick = $urandom_range(0, 29);
         if (pick == 0) len = $urandom_range(EDGE_CAP + 1, EDGE_CAP + 6);
         else if (pick < 5) len = $urandom_range(13, 40);
         else len = $urandom_range(1, 12);
         feed_random_list(len);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (survivors_due.size() != 0) @(posedge clock);
      repeat (2 * EDGE_CAP + 20) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
